// ===== rtl/mmm_pkg.sv =====
`timescale 1ns / 1ps
package mmm_pkg;
	localparam int DEF_NUM_WORDS = 8;
	localparam int DEF_WORD_BITS = 32;
	localparam int IDX_W = 3;
	localparam int CFG_W = 32;
	localparam int FIELD_W = 32;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_RED  = 7'b0000100,
		ST_PROP = 7'b0001000,
		ST_CMP  = 7'b0010000,
		ST_SUB  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic clear;      // clear accumulator, start of operation
		logic mul_step;   // a[j]*b[i] MAC
		logic red_z;      // take z for row i
		logic red_step;   // z*n[j] MAC
		logic prop_step;  // carry ripple
		logic cmp_step;   // compare top-down
		logic sub_step;   // subtract
		logic row_end;    // write carry into i+N (multiply pass only)
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic carry_zero;
		logic top_set;
		logic cmp_lt;
		logic cmp_gt;
	} stat_t;
endpackage

// ===== rtl/mmm_datapath.sv =====
`timescale 1ns / 1ps
module mmm_datapath #(
	parameter int NUM_WORDS = mmm_pkg::DEF_NUM_WORDS,
	parameter int WORD_BITS = mmm_pkg::DEF_WORD_BITS,
	parameter int CW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
	parameter int AW = $clog2(2 * NUM_WORDS + 1)
) (
	input  logic                       clk,
	input  logic                       load,
	input  logic [mmm_pkg::IDX_W-1:0]  load_idx,
	input  logic [mmm_pkg::FIELD_W-1:0] a_in,
	input  logic [mmm_pkg::FIELD_W-1:0] b_in,
	input  logic [mmm_pkg::FIELD_W-1:0] n_in,
	input  logic [WORD_BITS-1:0]       ninv,
	input  mmm_pkg::ctrl_t             ctrl,
	input  logic [CW-1:0]              i_idx,
	input  logic [CW-1:0]              j_idx,
	input  logic [AW-1:0]              p_idx,
	output mmm_pkg::stat_t             stat,
	output logic [WORD_BITS-1:0]       out_word
);
	import mmm_pkg::*;
	localparam int ACC = 2 * NUM_WORDS + 1;

	logic [WORD_BITS-1:0] a_mem [NUM_WORDS];
	logic [WORD_BITS-1:0] b_mem [NUM_WORDS];
	logic [WORD_BITS-1:0] n_mem [NUM_WORDS];
	logic [WORD_BITS-1:0] acc_q [ACC];
	logic [WORD_BITS-1:0] carry_q, z_q;
	logic                 borrow_q;

	logic [AW-1:0]        ij;
	logic [WORD_BITS-1:0] op_x, op_y, acc_rd, hi_w, n_w;
	logic [2*WORD_BITS-1:0] mac;
	logic [WORD_BITS:0]   psum, dsub;
	logic [2*WORD_BITS-1:0] zprod;

	always_ff @(posedge clk) begin
		if (load && {{(32-IDX_W){1'b0}}, load_idx} < NUM_WORDS) begin
			a_mem[load_idx[CW-1:0]] <= a_in[WORD_BITS-1:0];
			b_mem[load_idx[CW-1:0]] <= b_in[WORD_BITS-1:0];
			n_mem[load_idx[CW-1:0]] <= n_in[WORD_BITS-1:0];
		end
	end

	assign ij     = AW'(i_idx) + AW'(j_idx);
	assign acc_rd = acc_q[ij];
	assign op_x   = ctrl.mul_step ? a_mem[j_idx] : z_q;
	assign op_y   = ctrl.mul_step ? b_mem[i_idx] : n_mem[j_idx];
	assign mac    = op_x * op_y + {{WORD_BITS{1'b0}}, acc_rd} + {{WORD_BITS{1'b0}}, carry_q};
	assign zprod  = acc_q[AW'(i_idx)] * ninv;
	assign psum   = {1'b0, acc_q[p_idx]} + {1'b0, carry_q};
	assign hi_w   = acc_q[AW'(NUM_WORDS) + AW'(j_idx)];
	assign n_w    = n_mem[j_idx];
	assign dsub   = {1'b0, hi_w} - {1'b0, n_w} - {{WORD_BITS{1'b0}}, borrow_q};

	assign stat.carry_zero = (carry_q == '0) || (p_idx >= AW'(ACC));
	assign stat.top_set    = acc_q[ACC-1] != '0;
	assign stat.cmp_lt     = hi_w < n_w;
	assign stat.cmp_gt     = hi_w > n_w;
	assign out_word        = hi_w;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			for (int k = 0; k < ACC; k++) acc_q[k] <= '0;
			carry_q  <= '0;
			borrow_q <= 1'b0;
		end else if (ctrl.mul_step || ctrl.red_step) begin
			acc_q[ij] <= mac[WORD_BITS-1:0];
			carry_q   <= mac[2*WORD_BITS-1:WORD_BITS];
		end else if (ctrl.row_end) begin
			// multiply pass: carry lands in word i+N
			acc_q[AW'(i_idx) + AW'(NUM_WORDS)] <= carry_q;
			carry_q <= '0;
		end else if (ctrl.red_z) begin
			z_q     <= zprod[WORD_BITS-1:0];
			carry_q <= '0;
		end else if (ctrl.prop_step) begin
			acc_q[p_idx] <= psum[WORD_BITS-1:0];
			carry_q      <= {{(WORD_BITS-1){1'b0}}, psum[WORD_BITS]};
		end else if (ctrl.cmp_step && stat.top_set) begin
			// top word set: drop it, the subtract follows unconditionally
			acc_q[ACC-1] <= '0;
		end else if (ctrl.sub_step) begin
			acc_q[AW'(NUM_WORDS) + AW'(j_idx)] <= dsub[WORD_BITS-1:0];
			borrow_q <= dsub[WORD_BITS];
		end
	end
endmodule

// ===== rtl/mmm_ctrl.sv =====
`timescale 1ns / 1ps
module mmm_ctrl #(
	parameter int NUM_WORDS = mmm_pkg::DEF_NUM_WORDS,
	parameter int CW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
	parameter int AW = $clog2(2 * NUM_WORDS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  mmm_pkg::stat_t stat,
	output mmm_pkg::ctrl_t ctrl,
	output logic [CW-1:0]  i_idx,
	output logic [CW-1:0]  j_idx,
	output logic [AW-1:0]  p_idx,
	output logic           busy
);
	import mmm_pkg::*;
	localparam logic [CW-1:0] LAST = CW'(NUM_WORDS - 1);
	localparam int ACC = 2 * NUM_WORDS + 1;

	state_t state_q;
	logic [CW-1:0] i_q, j_q;
	logic [AW-1:0] p_q;
	logic          rowend_q;

	assign i_idx = i_q;
	assign j_idx = j_q;
	assign p_idx = p_q;
	assign busy  = (state_q != ST_IDLE);

	always_comb begin
		ctrl = '0;
		ctrl.clear     = (state_q == ST_IDLE) && go;
		ctrl.mul_step  = (state_q == ST_MUL) && !rowend_q;
		ctrl.row_end   = (state_q == ST_MUL) && rowend_q;
		ctrl.red_z     = (state_q == ST_RED) && rowend_q;
		ctrl.red_step  = (state_q == ST_RED) && !rowend_q;
		ctrl.prop_step = (state_q == ST_PROP) && !stat.carry_zero;
		ctrl.cmp_step  = (state_q == ST_CMP);
		ctrl.sub_step  = (state_q == ST_SUB);
		ctrl.emit      = (state_q == ST_OUT);
	end

	// rowend_q: in MUL marks the carry write after a row; in RED marks the z step before a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0; j_q <= '0; p_q <= '0; rowend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (go) begin
					state_q <= ST_MUL; i_q <= '0; j_q <= '0; rowend_q <= 1'b0;
				end
				ST_MUL: begin
					if (rowend_q) begin
						rowend_q <= 1'b0;
						j_q <= '0;
						if (i_q == LAST) begin
							state_q <= ST_RED; i_q <= '0; rowend_q <= 1'b1;
						end else i_q <= i_q + 1'b1;
					end else if (j_q == LAST) rowend_q <= 1'b1;
					else j_q <= j_q + 1'b1;
				end
				ST_RED: begin
					if (rowend_q) rowend_q <= 1'b0;
					else if (j_q == LAST) begin
						state_q <= ST_PROP;
						p_q <= AW'(i_q) + AW'(NUM_WORDS);
					end else j_q <= j_q + 1'b1;
				end
				ST_PROP: begin
					if (stat.carry_zero) begin
						if (i_q == LAST) begin
							state_q <= ST_CMP; j_q <= LAST;
						end else begin
							state_q <= ST_RED; i_q <= i_q + 1'b1; rowend_q <= 1'b1;
							j_q <= '0;
						end
					end else p_q <= p_q + 1'b1;
				end
				ST_CMP: begin
					if (stat.top_set || stat.cmp_gt || (!stat.cmp_lt && j_q == '0)) begin
						state_q <= ST_SUB; j_q <= '0;
					end else if (stat.cmp_lt) begin
						state_q <= ST_OUT; j_q <= '0;
					end else j_q <= j_q - 1'b1;
				end
				ST_SUB: begin
					if (j_q == LAST) begin state_q <= ST_OUT; j_q <= '0; end
					else j_q <= j_q + 1'b1;
				end
				ST_OUT: begin
					if (j_q == LAST) begin state_q <= ST_IDLE; j_q <= '0; end
					else j_q <= j_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && go) |=> (state_q == ST_MUL))
		else $error("start not taken");
	a_prop_rng: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.prop_step |-> (p_q < AW'(ACC)))
		else $error("ripple past top");
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && j_q == LAST) |=> !busy)
		else $error("no return to idle");
endmodule

// ===== rtl/montgomery_modular_multiplier_unit.sv =====
`timescale 1ns / 1ps
// channel   | handshake               | payload
// in        | start & !busy           | word_index a_word b_word modulus_word start_flag
// result    | result_valid (strobe)   | result_index result_word final_word
// cfg       | cfg_valid & cfg_ready   | cfg_data
// A load without start_flag writes the operand word and leaves the unit idle. With start_flag
// the unit stays busy through the multiply pass, the reduction pass with carry ripple, the
// compare, the subtract and the output pass; both passes share one word multiplier.
// Results come out on N consecutive strobes; the receiver cannot stall them.
// Reset clears control state and the stored cfg_data only; operand stores are undefined until loaded.
module montgomery_modular_multiplier_unit #(
	parameter int NUM_WORDS = mmm_pkg::DEF_NUM_WORDS,
	parameter int WORD_BITS = mmm_pkg::DEF_WORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  word_index,
	input  logic [31:0] a_word,
	input  logic [31:0] b_word,
	input  logic [31:0] modulus_word,
	input  logic        start_flag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic [2:0]  result_index,
	output logic [31:0] result_word,
	output logic        final_word
);
	import mmm_pkg::*;
	localparam int CW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int AW = $clog2(2 * NUM_WORDS + 1);

	logic [CFG_W-1:0] ninv_q;
	ctrl_t ctrl;
	stat_t stat;
	logic [CW-1:0] i_idx, j_idx;
	logic [AW-1:0] p_idx;
	logic [WORD_BITS-1:0] out_w;
	logic busy_w, load, go;

	assign load = start && !busy_w;
	assign go   = load && start_flag;
	assign busy = busy_w;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ninv_q <= '0;
		else if (cfg_valid && cfg_ready) ninv_q <= cfg_data;
	end

	mmm_ctrl #(.NUM_WORDS(NUM_WORDS)) u_ctrl (
		.clk, .arst_n, .go, .stat, .ctrl, .i_idx, .j_idx, .p_idx, .busy(busy_w)
	);

	mmm_datapath #(.NUM_WORDS(NUM_WORDS), .WORD_BITS(WORD_BITS)) u_dp (
		.clk, .load, .load_idx(word_index), .a_in(a_word), .b_in(b_word),
		.n_in(modulus_word), .ninv(ninv_q[WORD_BITS-1:0]), .ctrl, .i_idx, .j_idx,
		.p_idx, .stat, .out_word(out_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= ctrl.emit;
	end
	always_ff @(posedge clk) begin
		result_index <= IDX_W'(j_idx);
		result_word  <= FIELD_W'(out_w);
		final_word   <= (j_idx == CW'(NUM_WORDS - 1));
	end
endmodule
